>>> sv/tdt_pkg.sv
package tdt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int ID_W = 4;
    localparam int FIELD_TIME_W = 48;
    localparam int PERIOD_W = 32;
    localparam logic [31:0] WINDOW_RESET = 32'd3600000;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_CANCEL = 3'd1,
        FN_REFRESH = 3'd2,
        FN_RESET = 3'd3,
        FN_SCAN = 3'd4,
        FN_QUERY = 3'd5
    } func_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] timer_id;
        logic [31:0] period_ms;
        logic recurring;
        logic start_now;
        logic [47:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_id;
        logic [47:0] remaining_ms;
        logic wake;
        logic last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input word, clear the walk
        logic walk;        // compare the slot under the walk index
        logic walk_clear;  // restart the walk for a new search
        logic fire;        // fire the found slot during a scan
        logic finish;      // perform the single-slot update
        logic emit;        // build the result word
        logic emit_last;
    } tdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
        logic found;
        logic more;
    } tdt_sts_t;

endpackage

>>> sv/tdt_ctrl.sv
module tdt_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [2:0] in_func,
    input  logic out_stall,
    output logic out_valid,
    output tdt_pkg::tdt_cmd_t cmd,
    input  tdt_pkg::tdt_sts_t sts
);
    import tdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FINISH,
        S_OUT,
        S_SCAN,
        S_SCAN_OUT
    } state_t;

    state_t state_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = accept;
        cmd.walk = (state_reg == S_WALK) || (state_reg == S_SCAN);
        cmd.walk_clear = (state_reg == S_SCAN_OUT);
        cmd.fire = (state_reg == S_SCAN) && sts.walk_done && sts.found && out_free;
        cmd.finish = (state_reg == S_FINISH) && out_free;
        cmd.emit = cmd.finish || ((state_reg == S_SCAN) && sts.walk_done && out_free);
        cmd.emit_last = (state_reg == S_SCAN) && sts.walk_done && (!sts.found || !sts.more);
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_func <= FN_QUERY)
                    begin
                        state_reg <= (in_func == FN_SCAN) ? S_SCAN : S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (sts.walk_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (sts.walk_done && out_free)
                    begin
                        state_reg <= (sts.found && sts.more) ? S_SCAN_OUT : S_IDLE;
                    end
                end
                S_SCAN_OUT:
                begin
                    state_reg <= S_SCAN;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> sv/tdt_dp.sv
module tdt_dp
#(
    parameter int NUM_TIMERS = tdt_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS = tdt_pkg::TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  tdt_pkg::in_word_t in_word,
    input  logic cfg_valid,
    input  logic [31:0] cfg_data,
    input  tdt_pkg::tdt_cmd_t cmd,
    output tdt_pkg::tdt_sts_t sts,
    input  logic out_hold,
    output tdt_pkg::out_word_t out_word
);
    import tdt_pkg::*;

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] deadline_reg [NUM_TIMERS];
    logic [31:0] period_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] repeat_reg;
    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] fired_reg;
    logic wake_pending_reg;
    logic [TIME_BITS-1:0] prev_time_reg;
    logic [31:0] window_reg;
    in_word_t in_reg;
    logic roll_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] best_reg;
    logic found_reg;
    logic more_reg;
    logic [IDX_W-1:0] free_reg;
    logic free_found_reg;
    logic front_reg;
    out_word_t out_reg;

    logic [TIME_BITS-1:0] now;
    logic [IDX_W-1:0] cur;
    logic [TIME_BITS-1:0] cur_dl;
    logic [TIME_BITS-1:0] best_dl;
    logic cand;
    logic better;
    logic walk_done;
    logic tgt_ok;
    logic [IDX_W-1:0] tgt;
    logic tgt_valid;
    logic [TIME_BITS-1:0] tgt_dl;
    logic [31:0] tgt_per;
    logic [TIME_BITS-1:0] new_dl;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS:0] sum;
    logic [TIME_BITS-1:0] add_a;
    logic [31:0] add_b;
    logic [IDX_W-1:0] upd;
    logic upd_front;
    logic reset_same;
    logic [TIME_BITS-1:0] fire_dl;
    logic [TIME_BITS:0] fire_sum;
    logic tie_before;
    logic subj_before;
    logic front_ok;

    assign now = TIME_BITS'(in_reg.now_ms);
    assign cur = idx_reg[IDX_W-1:0];
    assign cur_dl = deadline_reg[cur];
    assign best_dl = deadline_reg[best_reg];
    assign tgt_ok = 32'(in_reg.timer_id) < NUM_TIMERS;
    assign tgt = IDX_W'(in_reg.timer_id);
    assign tgt_valid = tgt_ok && active_reg[tgt];
    assign tgt_dl = deadline_reg[tgt];
    assign tgt_per = period_reg[tgt];
    assign walk_done = (idx_reg == CNT_W'(NUM_TIMERS));
    assign out_word = out_reg;
    assign reset_same = tgt_ok && in_reg.period_ms == tgt_per && !in_reg.start_now;
    assign upd_front = front_reg;

    always_comb
    begin
        sts.walk_done = walk_done;
        sts.found = found_reg;
        sts.more = more_reg;
    end

    // During scans the walk skips fired slots and, unless a rollover was seen, not-yet-due slots.
    always_comb
    begin
        cand = active_reg[cur];
        if (in_reg.func == FN_SCAN)
        begin
            cand = cand && !fired_reg[cur] && (roll_reg || cur_dl <= now);
        end
        better = !found_reg || cur_dl < best_dl;
    end

    // Start and new deadline for the single-slot update, and the next deadline of a fired slot.
    always_comb
    begin
        start = now;
        add_b = in_reg.period_ms;
        upd = tgt;
        priority case (1'b1)
            (in_reg.func == FN_ADD):
            begin
                upd = free_reg;
            end
            (in_reg.func == FN_REFRESH):
            begin
                add_b = tgt_per;
            end
            (in_reg.func == FN_RESET && !in_reg.start_now):
            begin
                start = (tgt_dl >= TIME_BITS'(tgt_per)) ? tgt_dl - TIME_BITS'(tgt_per) : '0;
            end
            default:
            begin
                start = now;
            end
        endcase
        add_a = start;
        sum = {1'b0, add_a} + (TIME_BITS + 1)'(add_b);
        new_dl = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
        fire_sum = {1'b0, now} + (TIME_BITS + 1)'(period_reg[best_reg]);
        fire_dl = fire_sum[TIME_BITS] ? TMAX : fire_sum[TIME_BITS-1:0];
    end

    // The updated slot is the front when its new deadline precedes every other
    // active slot. An added slot is the lowest free one, so it precedes an equal
    // deadline only in slots above it, which the walk reaches after the free slot.
    always_comb
    begin
        tie_before = (in_reg.func == FN_ADD) ? free_found_reg : (tgt < cur);
        subj_before = (new_dl < cur_dl) || (new_dl == cur_dl && tie_before);
        front_ok = !active_reg[cur] || (in_reg.func != FN_ADD && cur == tgt)
                   || subj_before;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            repeat_reg <= '0;
            wake_pending_reg <= 1'b0;
            prev_time_reg <= '0;
            window_reg <= WINDOW_RESET;
            in_reg <= '0;
            idx_reg <= '0;
            best_reg <= '0;
            found_reg <= 1'b0;
            more_reg <= 1'b0;
            fired_reg <= '0;
            free_reg <= '0;
            free_found_reg <= 1'b0;
            front_reg <= 1'b0;
            roll_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                deadline_reg[i] <= '0;
                period_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                window_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                in_reg <= in_word;
                idx_reg <= '0;
                found_reg <= 1'b0;
                more_reg <= 1'b0;
                fired_reg <= '0;
                free_found_reg <= 1'b0;
                front_reg <= 1'b1;
                roll_reg <= (prev_time_reg >= TIME_BITS'(window_reg))
                            && (TIME_BITS'(in_word.now_ms)
                                < prev_time_reg - TIME_BITS'(window_reg));
                if (in_word.func == FN_SCAN)
                begin
                    prev_time_reg <= TIME_BITS'(in_word.now_ms);
                end
            end
            if (cmd.walk && !walk_done)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand && better)
                begin
                    best_reg <= cur;
                    found_reg <= 1'b1;
                end
                if (cand && found_reg)
                begin
                    more_reg <= 1'b1;
                end
                if (!active_reg[cur] && !free_found_reg)
                begin
                    free_reg <= cur;
                    free_found_reg <= 1'b1;
                end
                if (in_reg.func != FN_SCAN && !front_ok)
                begin
                    front_reg <= 1'b0;
                end
            end
            if (cmd.walk_clear)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                more_reg <= 1'b0;
            end
            if (cmd.fire)
            begin
                fired_reg[best_reg] <= 1'b1;
                if (repeat_reg[best_reg])
                begin
                    deadline_reg[best_reg] <= fire_dl;
                end
                else
                begin
                    active_reg[best_reg] <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                unique case (in_reg.func)
                    FN_ADD:
                    begin
                        if (free_found_reg)
                        begin
                            active_reg[upd] <= 1'b1;
                            period_reg[upd] <= in_reg.period_ms;
                            repeat_reg[upd] <= in_reg.recurring;
                            deadline_reg[upd] <= new_dl;
                            if (upd_front && !wake_pending_reg)
                            begin
                                wake_pending_reg <= 1'b1;
                            end
                        end
                    end
                    FN_CANCEL:
                    begin
                        if (tgt_valid)
                        begin
                            active_reg[tgt] <= 1'b0;
                        end
                    end
                    FN_REFRESH:
                    begin
                        if (tgt_valid)
                        begin
                            deadline_reg[tgt] <= new_dl;
                        end
                    end
                    FN_RESET:
                    begin
                        if (!reset_same && tgt_valid)
                        begin
                            period_reg[tgt] <= in_reg.period_ms;
                            deadline_reg[tgt] <= new_dl;
                            if (upd_front && !wake_pending_reg)
                            begin
                                wake_pending_reg <= 1'b1;
                            end
                        end
                    end
                    FN_QUERY:
                    begin
                        wake_pending_reg <= 1'b0;
                    end
                    default:
                    begin
                        wake_pending_reg <= wake_pending_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (cmd.emit && !out_hold)
        begin
            out_reg <= '0;
            if (in_reg.func == FN_SCAN)
            begin
                out_reg.status <= cmd.fire ? ST_OK : ST_NONE;
                out_reg.slot_id <= cmd.fire ? 4'(best_reg) : 4'd0;
                out_reg.last <= cmd.emit_last;
            end
            else
            begin
                unique case (in_reg.func)
                    FN_ADD:
                    begin
                        out_reg.status <= free_found_reg ? ST_OK : ST_FULL;
                        out_reg.slot_id <= free_found_reg ? 4'(free_reg) : 4'd0;
                        out_reg.wake <= free_found_reg && upd_front && !wake_pending_reg;
                    end
                    FN_CANCEL, FN_REFRESH:
                    begin
                        out_reg.status <= tgt_valid ? ST_OK : ST_REFUSED;
                    end
                    FN_RESET:
                    begin
                        out_reg.status <= (reset_same || tgt_valid) ? ST_OK : ST_REFUSED;
                        out_reg.wake <= !reset_same && tgt_valid && upd_front
                                        && !wake_pending_reg;
                    end
                    FN_QUERY:
                    begin
                        out_reg.status <= found_reg ? ST_OK : ST_NONE;
                        out_reg.remaining_ms <= !found_reg ? '1
                            : (now >= best_dl) ? '0 : 48'(best_dl - now);
                    end
                    default:
                    begin
                        out_reg.status <= ST_NONE;
                    end
                endcase
            end
        end
    end
endmodule

>>> sv/timer_deadline_table.sv
// Channel | Handshake             | Payload
// input   | in_valid / in_stall   | in_data, word toward the table
// output  | out_valid / out_stall | out_data, result word from the table
// config  | cfg_valid / cfg_ready | cfg_data, rollover window register
//
// One comparator walks the NUM_TIMERS slots, one slot per cycle.
// A non-scan item with a defined function walks all slots, then registers its word once
// the output is free; codes above FN_QUERY give no word. A scan registers one word per
// expired slot or one ST_NONE word, walking anew after each; the input stalls meanwhile.
// Reset clears all slots to inactive at once and sets the window to one hour.
// A word held by out_stall holds back the next update and word, not the walk.
module timer_deadline_table
#(
    parameter int NUM_TIMERS = tdt_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS = tdt_pkg::TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  tdt_pkg::in_word_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output tdt_pkg::out_word_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [31:0] cfg_data
);
    import tdt_pkg::*;

    tdt_cmd_t cmd;
    tdt_sts_t sts;

    assign cfg_ready = 1'b1;

    tdt_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_func(in_data.func),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .cmd(cmd),
        .sts(sts)
    );

    tdt_dp #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_word(in_data),
        .cfg_valid(cfg_valid),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .sts(sts),
        .out_hold(out_valid && out_stall),
        .out_word(out_data)
    );
endmodule

>>> tb/timer_deadline_table_test.sv
`timescale 1ns / 1ps

module timer_deadline_table_test;
    import tdt_pkg::*;

    localparam int NT = 16;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam int LIMIT = 3000000;

    class timer_scoreboard;
        logic [47:0] deadline [NT];
        logic [31:0] period [NT];
        bit repeat_flag [NT];
        bit active [NT];
        bit wake_pending;
        logic [47:0] prev_time;
        logic [31:0] window;
        out_word_t pending_q [$];
        int errors;
        int checked;

        function void clear();
            for (int i = 0; i < NT; i++)
            begin
                deadline[i] = '0;
                period[i] = '0;
                repeat_flag[i] = 0;
                active[i] = 0;
            end
            wake_pending = 0;
            prev_time = '0;
            window = WINDOW_RESET;
            pending_q.delete();
            errors = 0;
            checked = 0;
        endfunction

        function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? TMAX : s[47:0];
        endfunction

        function bit earlier(int a, int b);
            return deadline[a] < deadline[b] || (deadline[a] == deadline[b] && a < b);
        endfunction

        function bit claim_wake(int s);
            bit front;
            front = 1;
            for (int j = 0; j < NT; j++)
                if (j != s && active[j] && !earlier(s, j))
                    front = 0;
            if (front && !wake_pending)
            begin
                wake_pending = 1;
                return 1;
            end
            return 0;
        endfunction

        function void push(logic [1:0] st, logic [3:0] slot, logic [47:0] rem, bit wk,
                           bit lst);
            out_word_t w;
            w.status = st;
            w.slot_id = slot;
            w.remaining_ms = rem;
            w.wake = wk;
            w.last = lst;
            pending_q.insert(pending_q.size(), w);
        endfunction

        function void note_input(in_word_t x);
            int id;
            int s;
            int best;
            int n;
            bit ok;
            bit roll;
            bit fired [NT];
            logic [47:0] start;
            id = x.timer_id;
            ok = active[id];
            case (x.func)
                FN_ADD:
                begin
                    s = NT;
                    for (int j = NT - 1; j >= 0; j--)
                        if (!active[j])
                            s = j;
                    if (s == NT)
                        push(ST_FULL, 0, 0, 0, 0);
                    else
                    begin
                        active[s] = 1;
                        period[s] = x.period_ms;
                        repeat_flag[s] = x.recurring;
                        deadline[s] = sat_sum(x.now_ms, {16'd0, x.period_ms});
                        push(ST_OK, s[3:0], 0, claim_wake(s), 0);
                    end
                end
                FN_CANCEL:
                begin
                    if (!ok)
                        push(ST_REFUSED, 0, 0, 0, 0);
                    else
                    begin
                        active[id] = 0;
                        push(ST_OK, 0, 0, 0, 0);
                    end
                end
                FN_REFRESH:
                begin
                    if (!ok)
                        push(ST_REFUSED, 0, 0, 0, 0);
                    else
                    begin
                        deadline[id] = sat_sum(x.now_ms, {16'd0, period[id]});
                        push(ST_OK, 0, 0, 0, 0);
                    end
                end
                FN_RESET:
                begin
                    if (x.period_ms == period[id] && !x.start_now)
                        push(ST_OK, 0, 0, 0, 0);
                    else if (!ok)
                        push(ST_REFUSED, 0, 0, 0, 0);
                    else
                    begin
                        if (x.start_now)
                            start = x.now_ms;
                        else if (deadline[id] >= {16'd0, period[id]})
                            start = deadline[id] - {16'd0, period[id]};
                        else
                            start = '0;
                        period[id] = x.period_ms;
                        deadline[id] = sat_sum(start, {16'd0, x.period_ms});
                        push(ST_OK, 0, 0, claim_wake(id), 0);
                    end
                end
                FN_SCAN:
                begin
                    roll = prev_time >= {16'd0, window}
                        && x.now_ms < prev_time - {16'd0, window};
                    prev_time = x.now_ms;
                    n = 0;
                    for (int j = 0; j < NT; j++)
                        fired[j] = 0;
                    while (n < NT)
                    begin
                        best = NT;
                        for (int j = 0; j < NT; j++)
                        begin
                            if (active[j] && !fired[j] && (roll || deadline[j] <= x.now_ms))
                                if (best == NT || earlier(j, best))
                                    best = j;
                        end
                        if (best == NT)
                            break;
                        fired[best] = 1;
                        if (repeat_flag[best])
                            deadline[best] = sat_sum(x.now_ms, {16'd0, period[best]});
                        else
                            active[best] = 0;
                        push(ST_OK, best[3:0], 0, 0, 0);
                        n++;
                    end
                    if (n == 0)
                        push(ST_NONE, 0, 0, 0, 1);
                    else
                        pending_q[$].last = 1;
                end
                FN_QUERY:
                begin
                    wake_pending = 0;
                    best = NT;
                    for (int j = 0; j < NT; j++)
                        if (active[j] && (best == NT || earlier(j, best)))
                            best = j;
                    if (best == NT)
                        push(ST_NONE, 0, TMAX, 0, 0);
                    else
                        push(ST_OK, 0, x.now_ms >= deadline[best] ? 48'd0
                             : deadline[best] - x.now_ms, 0, 0);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (pending_q.size() == 0)
            begin
                $error("Unexpected result word %h", got);
                errors++;
                return;
            end
            exp_w = pending_q.pop_front();
            checked++;
            if (got.status !== exp_w.status)
            begin
                $error("status expected %0d actual %0d", exp_w.status, got.status);
                errors++;
            end
            if (got.slot_id !== exp_w.slot_id)
            begin
                $error("slot_id expected %0d actual %0d", exp_w.slot_id, got.slot_id);
                errors++;
            end
            if (got.remaining_ms !== exp_w.remaining_ms)
            begin
                $error("remaining_ms expected %0d actual %0d", exp_w.remaining_ms,
                       got.remaining_ms);
                errors++;
            end
            if (got.wake !== exp_w.wake)
            begin
                $error("wake expected %0d actual %0d", exp_w.wake, got.wake);
                errors++;
            end
            if (got.last !== exp_w.last)
            begin
                $error("last expected %0d actual %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_data;
    logic out_valid;
    logic out_stall;
    out_word_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;

    timer_scoreboard board;
    int cycle_count;
    int words_sent;
    int hold_cycles;
    logic [47:0] clock_ms;
    int add_count;
    int scan_count;

    timer_deadline_table DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    function int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    initial
    begin
        int g;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                if (g == 0)
                    out_stall <= 0;
                else
                begin
                    out_stall <= 1;
                    repeat (g) @(negedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic send_word(in_word_t w);
        int g;
        g = gap_len();
        if (g == 0 || $urandom_range(0, 3) == 0)
            g = 1;
        repeat (g) @(negedge clk);
        in_data <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(w);
        words_sent++;
        if (w.func == FN_ADD)
            add_count++;
        if (w.func == FN_SCAN)
            scan_count++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (NT * (NT + 2) + 20) @(negedge clk);
    endtask

    task automatic write_window(logic [31:0] v);
        drain();
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.window = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic in_word_t make_word(func_t f, int id, logic [31:0] p, bit r,
                                           bit fn, logic [47:0] t);
        in_word_t w;
        w.func = f;
        w.timer_id = id[3:0];
        w.period_ms = p;
        w.recurring = r;
        w.start_now = fn;
        w.now_ms = t;
        return w;
    endfunction

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    task automatic random_word();
        in_word_t w;
        int k;
        k = $urandom_range(0, 99);
        if (k < 3)
            clock_ms = 48'({$urandom, $urandom});
        else if (k < 6)
            clock_ms = (clock_ms > 48'd5000000) ? clock_ms - $urandom_range(0, 8000000)
                : clock_ms;
        else
            clock_ms = clock_ms + $urandom_range(0, 150);
        w.now_ms = clock_ms;
        w.timer_id = 4'($urandom_range(0, 15));
        w.period_ms = rand_period();
        w.recurring = 1'($urandom_range(0, 1));
        w.start_now = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 30)
            w.func = FN_ADD;
        else if (k < 40)
            w.func = FN_CANCEL;
        else if (k < 50)
            w.func = FN_REFRESH;
        else if (k < 62)
        begin
            w.func = FN_RESET;
            if ($urandom_range(0, 3) == 0)
                w.period_ms = board.period[w.timer_id];
        end
        else if (k < 82)
            w.func = FN_SCAN;
        else if (k < 97)
            w.func = FN_QUERY;
        else
            w.func = 3'($urandom_range(6, 7));
        send_word(w);
    endtask

    initial
    begin
        int i;
        board = new();
        board.clear();
        cycle_count = 0;
        words_sent = 0;
        hold_cycles = 0;
        add_count = 0;
        scan_count = 0;
        clock_ms = 48'd1000;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_word(make_word(FN_QUERY, 0, 0, 0, 0, 48'd0));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd0));
        send_word(make_word(FN_CANCEL, 15, 0, 0, 0, 48'd5));
        send_word(make_word(FN_REFRESH, 3, 0, 0, 0, 48'd5));
        send_word(make_word(FN_RESET, 2, 0, 0, 0, 48'd5));
        send_word(make_word(FN_RESET, 2, 7, 0, 1, 48'd5));
        send_word(make_word(FN_ADD, 0, 32'd10, 1, 0, 48'd100));
        send_word(make_word(FN_ADD, 0, 32'd10, 0, 0, 48'd100));
        send_word(make_word(FN_ADD, 0, 32'hFFFF_FFFF, 0, 0, TMAX));
        send_word(make_word(FN_ADD, 0, 32'd0, 1, 0, 48'd90));
        send_word(make_word(FN_QUERY, 0, 0, 0, 0, 48'd95));
        send_word(make_word(FN_RESET, 1, 32'd3, 0, 0, 48'd100));
        send_word(make_word(FN_RESET, 0, 32'd50, 0, 1, 48'd100));
        send_word(make_word(FN_REFRESH, 1, 0, 0, 0, 48'd104));
        send_word(make_word(func_t'(3'd6), 0, 0, 0, 0, 48'd0));
        send_word(make_word(func_t'(3'd7), 15, 32'hFFFF_FFFF, 1, 1, TMAX));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd200));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd200));
        for (i = 0; i < 17; i++)
            send_word(make_word(FN_ADD, 0, 32'd5, i[0], 0, 48'd300));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd305));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd305 + 48'd3600000));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd10));

        write_window(32'd1);
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd9));
        write_window(32'hFFFF_FFFF);
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, TMAX));
        send_word(make_word(FN_SCAN, 0, 0, 0, 0, 48'd0));
        write_window(32'd5000);

        for (i = 0; i < 400; i++)
        begin
            if (i == 150)
                hold_cycles = 600;
            if (i == 250)
                drain();
            if (i == 300)
                write_window($urandom_range(1, 200000));
            random_word();
        end
        drain();
        write_window(WINDOW_RESET);
        for (i = 0; i < 20; i++)
            random_word();
        drain();

        $display("Sent %0d words (%0d adds, %0d scans), checked %0d result words.",
                 words_sent, add_count, scan_count, board.checked);
        $display("Window settings covered 1, 5000, random, default and all ones.");
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
sv/tdt_pkg.sv
sv/tdt_ctrl.sv
sv/tdt_dp.sv
sv/timer_deadline_table.sv
tb/timer_deadline_table_test.sv
